@@ rtl/assert_macros.svh @@
// Assertion macros used by the top level of the text scroller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk_i, ignored while rst_ni is low.
`define ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: assertion failed");

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, cond) \
  `ASSERT_RST(label, !(cond))

`endif

@@ rtl/lmts_pkg.sv @@
// Package with the constants, types and helper functions of the text scroller.
package lmts_pkg;

  localparam int NUM_GLYPHS  = 26;
  localparam int MATRIX_SIZE = 8;
  localparam int OUT_ROWS    = 8;

  // Rows that are held and shown; rows past the matrix read as zero.
  localparam int NROWS       = (MATRIX_SIZE < OUT_ROWS) ? MATRIX_SIZE : OUT_ROWS;
  localparam int FONT_DEPTH  = NUM_GLYPHS * MATRIX_SIZE;
  localparam int FONT_AW     = $clog2(FONT_DEPTH);
  localparam int GLYPH_W     = $clog2(NUM_GLYPHS + 1);
  localparam int SHIFT_W     = $clog2(MATRIX_SIZE);
  localparam int ROW_SEL_W   = $clog2(NROWS);
  localparam int FETCH_CNT_W = $clog2(NROWS + 2);

  localparam logic [GLYPH_W-1:0] BLANK_GLYPH = GLYPH_W'(NUM_GLYPHS);
  localparam logic [7:0] ROW_MASK =
    (MATRIX_SIZE >= 8) ? 8'hFF : 8'((1 << MATRIX_SIZE) - 1);

  localparam logic [7:0]  CHAR_UPPER_A = 8'd65;
  localparam logic [7:0]  CASE_OFFSET  = 8'd32;
  localparam logic [7:0]  CHAR_LOWER_A = 8'h61;
  localparam logic [7:0]  CHAR_LOWER_Z = 8'h7A;
  localparam logic [15:0] COLOR_RESET  = 16'hFFFF;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_CHAR = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EMIT_A,
    ST_EMIT_B
  } state_e;

  typedef logic [GLYPH_W-1:0]       glyph_t;
  typedef logic [MATRIX_SIZE-1:0]   mrow_t;
  typedef logic [2*MATRIX_SIZE-1:0] pair_t;

  typedef struct packed {
    cmd_e       command;
    logic [4:0] glyph_index;
    logic [2:0] glyph_row;
    logic [7:0] row_bits;
    logic [7:0] char_code;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  shift;
    logic [7:0]  row_0;
    logic [7:0]  row_1;
    logic [7:0]  row_2;
    logic [7:0]  row_3;
    logic [7:0]  row_4;
    logic [7:0]  row_5;
    logic [7:0]  row_6;
    logic [7:0]  row_7;
    logic [15:0] lit_color;
    logic        last_frame;
  } out_item_t;

  // Flags of the character being scrolled.
  typedef struct packed {
    logic have_prev;
    logic eom;
  } job_t;

  // Controls from the sequencer to the row shifter.
  typedef struct packed {
    logic                 cap_en;
    logic [ROW_SEL_W-1:0] cap_row;
    logic                 load_a;
    logic                 load_b;
    logic                 step;
  } shf_ctl_t;

  // Folds a-z to upper case and maps letters to glyphs; anything else is blank.
  function automatic glyph_t glyph_of_code(input logic [7:0] code);
    logic [7:0] c;
    c = code;
    if (c inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
      c = c - CASE_OFFSET;
    end
    if ((c < CHAR_UPPER_A) || (32'(c - CHAR_UPPER_A) >= NUM_GLYPHS)) begin
      return BLANK_GLYPH;
    end
    return GLYPH_W'(c - CHAR_UPPER_A);
  endfunction

endpackage

@@ rtl/led_matrix_text_scroller.sv @@
// Top level of the scrolling text marquee for the LED matrix.
//
//  Channel   Direction  Handshake               Payload
//  in        input      in_valid_i/in_ready_o   in_data_i   (lmts_pkg::in_item_t)
//  out       output     out_valid_o/out_ready_i out_data_o  (lmts_pkg::out_item_t)
//  cfg       input      cfg_we_i                cfg_wdata_i (pixel colour)
//
// A load word or a character that shows nothing is taken without leaving idle. A
// character that shows frames reads its glyph rows through both font store read
// ports, one row a cycle, then gives one frame per cycle from the row shifter
// while out_ready_i is high: 8 or 16 frames.
// Reset is asynchronous; the font store is not cleared and reads undefined
// until written. A stalled frame holds, and no input word is taken until the
// last frame of the character is taken.
`include "assert_macros.svh"

module led_matrix_text_scroller (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lmts_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lmts_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i
);

  logic [15:0]      color_q;
  lmts_pkg::glyph_t prev_glyph_q;
  logic             have_prev_q;
  lmts_pkg::glyph_t left_glyph_q;
  lmts_pkg::glyph_t cur_glyph_q;
  lmts_pkg::job_t   job_q;

  logic             in_fire;
  logic             is_char;
  logic             char_start;
  logic             font_we;
  logic [lmts_pkg::FONT_AW-1:0] font_waddr;
  logic [lmts_pkg::FONT_AW-1:0] rd_addr_left;
  logic [lmts_pkg::FONT_AW-1:0] rd_addr_cur;
  logic [7:0]       rd_left;
  logic [7:0]       rd_cur;
  lmts_pkg::glyph_t in_glyph;
  logic             left_blank;
  logic             cur_blank;

  logic [lmts_pkg::SHIFT_W-1:0]   shift;
  logic [lmts_pkg::ROW_SEL_W-1:0] rd_row;
  logic                           last_frame;
  lmts_pkg::shf_ctl_t             shf_ctl;
  logic [lmts_pkg::OUT_ROWS-1:0][7:0] rows;

  assign in_fire    = in_valid_i && in_ready_o;
  assign is_char    = (in_data_i.command == lmts_pkg::CMD_CHAR);
  assign char_start = in_fire && is_char && (have_prev_q || in_data_i.end_of_message);
  assign in_glyph   = lmts_pkg::glyph_of_code(in_data_i.char_code);

  // Loads outside the store are dropped.
  assign font_we = in_fire && !is_char &&
                   (32'(in_data_i.glyph_index) < lmts_pkg::NUM_GLYPHS) &&
                   (32'(in_data_i.glyph_row) < lmts_pkg::MATRIX_SIZE);
  assign font_waddr =
    lmts_pkg::FONT_AW'(in_data_i.glyph_index) *
    lmts_pkg::FONT_AW'(lmts_pkg::MATRIX_SIZE) +
    lmts_pkg::FONT_AW'(in_data_i.glyph_row);

  assign left_blank = (left_glyph_q == lmts_pkg::BLANK_GLYPH);
  assign cur_blank  = (cur_glyph_q == lmts_pkg::BLANK_GLYPH);

  // A blank glyph reads address zero; its rows are forced to zero on capture.
  assign rd_addr_left = left_blank ? '0 :
    lmts_pkg::FONT_AW'(left_glyph_q) * lmts_pkg::FONT_AW'(lmts_pkg::MATRIX_SIZE) +
    lmts_pkg::FONT_AW'(rd_row);
  assign rd_addr_cur = cur_blank ? '0 :
    lmts_pkg::FONT_AW'(cur_glyph_q) * lmts_pkg::FONT_AW'(lmts_pkg::MATRIX_SIZE) +
    lmts_pkg::FONT_AW'(rd_row);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q      <= lmts_pkg::COLOR_RESET;
      prev_glyph_q <= lmts_pkg::BLANK_GLYPH;
      have_prev_q  <= 1'b0;
      job_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        color_q <= cfg_wdata_i;
      end
      if (in_fire && is_char) begin
        job_q.have_prev <= have_prev_q;
        job_q.eom       <= in_data_i.end_of_message;
        if (in_data_i.end_of_message) begin
          prev_glyph_q <= lmts_pkg::BLANK_GLYPH;
          have_prev_q  <= 1'b0;
        end else begin
          prev_glyph_q <= in_glyph;
          have_prev_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && is_char) begin
      left_glyph_q <= prev_glyph_q;
      cur_glyph_q  <= in_glyph;
    end
  end

  lmts_ram #(
    .WIDTH (8),
    .DEPTH (lmts_pkg::FONT_DEPTH)
  ) u_font (
    .clk_i     (clk_i),
    .we_i      (font_we),
    .waddr_i   (font_waddr),
    .wdata_i   (in_data_i.row_bits & lmts_pkg::ROW_MASK),
    .raddr_a_i (rd_addr_left),
    .raddr_b_i (rd_addr_cur),
    .rdata_a_o (rd_left),
    .rdata_b_o (rd_cur)
  );

  lmts_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (char_start),
    .job_i        (job_q),
    .out_ready_i  (out_ready_i),
    .in_ready_o   (in_ready_o),
    .out_valid_o  (out_valid_o),
    .last_frame_o (last_frame),
    .shift_o      (shift),
    .rd_row_o     (rd_row),
    .ctl_o        (shf_ctl)
  );

  lmts_shifter u_shifter (
    .clk_i        (clk_i),
    .ctl_i        (shf_ctl),
    .left_blank_i (left_blank),
    .cur_blank_i  (cur_blank),
    .rd_left_i    (rd_left),
    .rd_cur_i     (rd_cur),
    .rows_o       (rows)
  );

  always_comb begin
    out_data_o            = '0;
    out_data_o.shift      = 3'(shift);
    out_data_o.row_0      = rows[0];
    out_data_o.row_1      = rows[1];
    out_data_o.row_2      = rows[2];
    out_data_o.row_3      = rows[3];
    out_data_o.row_4      = rows[4];
    out_data_o.row_5      = rows[5];
    out_data_o.row_6      = rows[6];
    out_data_o.row_7      = rows[7];
    out_data_o.lit_color  = color_q;
    out_data_o.last_frame = last_frame;
  end

  // The block never takes a word while a frame is on offer.
  `ASSERT_NEVER(a_ready_while_frame, in_ready_o && out_valid_o)
  // The final frame of a character hands control straight back to the input.
  `ASSERT_RST(a_last_frees_input,
    out_valid_o && out_ready_i && out_data_o.last_frame |=> in_ready_o)
  // Any frame that is not the last is followed by another one at once.
  `ASSERT_RST(a_frames_continue,
    out_valid_o && out_ready_i && !out_data_o.last_frame |=> out_valid_o)
  // A first character that does not end its message shows nothing.
  `ASSERT_RST(a_silent_first_char,
    in_valid_i && in_ready_o && (in_data_i.command == lmts_pkg::CMD_CHAR) &&
    !have_prev_q && !in_data_i.end_of_message |=> in_ready_o)

endmodule

@@ rtl/lmts_ram.sv @@
// Generic RAM with one write port and two registered read ports.
module lmts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 208,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

@@ rtl/lmts_shifter.sv @@
// Row registers and the per-row one-column shifters that build each frame.
module lmts_shifter (
  input  logic                           clk_i,
  input  lmts_pkg::shf_ctl_t             ctl_i,
  input  logic                           left_blank_i,
  input  logic                           cur_blank_i,
  input  logic [7:0]                     rd_left_i,
  input  logic [7:0]                     rd_cur_i,
  output logic [lmts_pkg::OUT_ROWS-1:0][7:0] rows_o
);

  lmts_pkg::mrow_t left_q [lmts_pkg::NROWS];
  lmts_pkg::mrow_t cur_q  [lmts_pkg::NROWS];
  lmts_pkg::pair_t pair_q [lmts_pkg::NROWS];

  always_ff @(posedge clk_i) begin
    if (ctl_i.cap_en) begin
      left_q[ctl_i.cap_row] <= left_blank_i ? '0 : lmts_pkg::mrow_t'(rd_left_i);
      cur_q[ctl_i.cap_row]  <= cur_blank_i  ? '0 : lmts_pkg::mrow_t'(rd_cur_i);
    end
    // The pair holds the right glyph above the left one; each frame moves
    // the window one column further right.
    for (int r = 0; r < lmts_pkg::NROWS; r++) begin
      if (ctl_i.load_a) begin
        pair_q[r] <= {cur_q[r], left_q[r]};
      end else if (ctl_i.load_b) begin
        pair_q[r] <= {lmts_pkg::mrow_t'(0), cur_q[r]};
      end else if (ctl_i.step) begin
        pair_q[r] <= pair_q[r] >> 1;
      end
    end
  end

  for (genvar r = 0; r < lmts_pkg::OUT_ROWS; r++) begin : g_rows
    if (r < lmts_pkg::NROWS) begin : g_shown
      assign rows_o[r] = 8'(pair_q[r][lmts_pkg::MATRIX_SIZE-1:0]);
    end else begin : g_blank
      assign rows_o[r] = '0;
    end
  end

endmodule

@@ rtl/lmts_seq.sv @@
// Sequencer: fetches glyph rows from the font store and steps through frames.
module lmts_seq (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  lmts_pkg::job_t                   job_i,
  input  logic                             out_ready_i,
  output logic                             in_ready_o,
  output logic                             out_valid_o,
  output logic                             last_frame_o,
  output logic [lmts_pkg::SHIFT_W-1:0]     shift_o,
  output logic [lmts_pkg::ROW_SEL_W-1:0]   rd_row_o,
  output lmts_pkg::shf_ctl_t               ctl_o
);

  lmts_pkg::state_e state_q, state_d;
  logic [lmts_pkg::FETCH_CNT_W-1:0] fetch_cnt_q, fetch_cnt_d;
  logic [lmts_pkg::SHIFT_W-1:0]     shift_q, shift_d;
  logic                             cap_en_q, cap_en_d;
  logic [lmts_pkg::ROW_SEL_W-1:0]   cap_row_q, cap_row_d;

  logic rd_issue;
  logic fetch_done;
  logic shift_last;
  logic out_fire;

  // The last row read is registered by the font store and lands in the cycle after
  // its address, so the fetch runs two counts past the final read address.
  assign rd_issue   = (state_q == lmts_pkg::ST_FETCH) &&
                      (fetch_cnt_q < lmts_pkg::FETCH_CNT_W'(lmts_pkg::NROWS));
  assign fetch_done = (state_q == lmts_pkg::ST_FETCH) &&
                      (fetch_cnt_q == lmts_pkg::FETCH_CNT_W'(lmts_pkg::NROWS + 1));
  assign shift_last = (shift_q == lmts_pkg::SHIFT_W'(lmts_pkg::MATRIX_SIZE - 1));
  assign out_fire   = out_valid_o && out_ready_i;
  assign rd_row_o   = fetch_cnt_q[lmts_pkg::ROW_SEL_W-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      lmts_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = lmts_pkg::ST_FETCH;
        end
      end
      lmts_pkg::ST_FETCH: begin
        if (fetch_done) begin
          state_d = job_i.have_prev ? lmts_pkg::ST_EMIT_A : lmts_pkg::ST_EMIT_B;
        end
      end
      lmts_pkg::ST_EMIT_A: begin
        if (out_fire && shift_last) begin
          state_d = job_i.eom ? lmts_pkg::ST_EMIT_B : lmts_pkg::ST_IDLE;
        end
      end
      lmts_pkg::ST_EMIT_B: begin
        if (out_fire && shift_last) begin
          state_d = lmts_pkg::ST_IDLE;
        end
      end
      default: state_d = lmts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    last_frame_o  = 1'b0;
    ctl_o         = '0;
    ctl_o.cap_en  = cap_en_q;
    ctl_o.cap_row = cap_row_q;
    case (state_q)
      lmts_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      lmts_pkg::ST_FETCH: begin
        ctl_o.load_a = fetch_done && job_i.have_prev;
        ctl_o.load_b = fetch_done && !job_i.have_prev;
      end
      lmts_pkg::ST_EMIT_A: begin
        out_valid_o  = 1'b1;
        last_frame_o = shift_last && !job_i.eom;
        ctl_o.load_b = out_fire && shift_last && job_i.eom;
        ctl_o.step   = out_fire && !shift_last;
      end
      lmts_pkg::ST_EMIT_B: begin
        out_valid_o  = 1'b1;
        last_frame_o = shift_last;
        ctl_o.step   = out_fire && !shift_last;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    fetch_cnt_d = fetch_cnt_q;
    shift_d     = shift_q;
    cap_en_d    = rd_issue;
    cap_row_d   = rd_row_o;
    if (state_q == lmts_pkg::ST_IDLE) begin
      fetch_cnt_d = '0;
    end else if ((state_q == lmts_pkg::ST_FETCH) && !fetch_done) begin
      fetch_cnt_d = fetch_cnt_q + 1'b1;
    end
    if (ctl_o.load_a || ctl_o.load_b) begin
      shift_d = '0;
    end else if (ctl_o.step) begin
      shift_d = shift_q + 1'b1;
    end
  end

  assign shift_o = shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lmts_pkg::ST_IDLE;
      fetch_cnt_q <= '0;
      shift_q     <= '0;
      cap_en_q    <= 1'b0;
      cap_row_q   <= '0;
    end else begin
      state_q     <= state_d;
      fetch_cnt_q <= fetch_cnt_d;
      shift_q     <= shift_d;
      cap_en_q    <= cap_en_d;
      cap_row_q   <= cap_row_d;
    end
  end

endmodule
